>>> rtl/core/pba_pkg.sv
// Package for the palette brightness adjuster.
// Holds widths, fixed-point constants and the command codes.
// No dependencies.
package pba_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CMD_W         = 2;
  localparam int CH_W          = 8;
  localparam int COLOR_W       = 3 * CH_W;
  localparam int TGT_W         = 10;
  localparam int COUNT_W       = 9;
  localparam int PADDR_W       = 2;
  localparam int PDATA_W       = 32;

  localparam int FRAC_BITS     = 16;
  localparam int PROD_W        = 18;
  localparam int NUM_W         = PROD_W;
  localparam int SUM_W         = 10;
  localparam int REM_W         = SUM_W;
  localparam int QUO_W         = 26;
  localparam int HEAD_W        = NUM_W + FRAC_BITS - QUO_W;
  localparam int FX_W          = 27;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(11);
  localparam logic [PADDR_W-1:0] REG_COUNT_ADDR = PADDR_W'(0);
  localparam logic [CH_W-1:0]    CH_MAX = {CH_W{1'b1}};
  localparam logic [FX_W-1:0]    LIMIT_FX = FX_W'(CH_MAX) << FRAC_BITS;
  localparam logic [FX_W-1:0]    INT_MASK = ~((FX_W'(1) << FRAC_BITS) - FX_W'(1));
  localparam logic [CH_W-1:0]    RECIP3 = CH_W'(171);
  localparam int                 RECIP3_SHIFT = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

endpackage

>>> rtl/core/pba_req_if.sv
// Command channel of the palette brightness adjuster.
// Depends on pba_pkg for field widths.
interface pba_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [pba_pkg::CMD_W-1:0]            cmd;
  logic [pba_pkg::IDX_W-1:0]            entry_index;
  logic [pba_pkg::CH_W-1:0]             new_red;
  logic [pba_pkg::CH_W-1:0]             new_green;
  logic [pba_pkg::CH_W-1:0]             new_blue;
  logic signed [pba_pkg::TGT_W-1:0]     target_brightness;

  modport source (
    output valid, cmd, entry_index, new_red, new_green, new_blue, target_brightness,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, new_red, new_green, new_blue, target_brightness,
    output ready
  );
endinterface

>>> rtl/core/pba_rsp_if.sv
// Result channel of the palette brightness adjuster.
// Depends on pba_pkg for field widths.
interface pba_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [pba_pkg::CH_W-1:0] out_red;
  logic [pba_pkg::CH_W-1:0] out_green;
  logic [pba_pkg::CH_W-1:0] out_blue;
  logic                     ok;

  modport source (
    output valid, out_red, out_green, out_blue, ok,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, ok,
    output ready
  );
endinterface

>>> rtl/core/palette_brightness_adjust.sv
// Top level of the palette brightness adjuster.
// Depends on pba_pkg, pba_req_if, pba_rsp_if and pba_div.
//
// Keeps a 256-entry palette of 24-bit colors and handles one command at a time: write,
// read or brightness adjust, each giving one result with the entry's new color and an ok
// flag. Rejected commands (index at or above palette_count) and writes go straight to the
// result, reads pass through fetch. An adjust of a black entry skips the divider, and the
// spill states run only when a channel spills. Most of an adjust's time is the 26-step
// bit-serial divider that forms the three scaled channels in parallel. The rest is fetch,
// launch, range check, write-back and output. The next command is taken while a result
// waits in the output register. Entries must be written before they are read or adjusted.
module palette_brightness_adjust (
  input  logic                           clk,
  input  logic                           rst,
  pba_req_if.sink                        req,
  pba_rsp_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pba_pkg::PADDR_W-1:0]    paddr,
  input  logic [pba_pkg::PDATA_W-1:0]    pwdata,
  output logic [pba_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_LAUNCH, S_DIV, S_PICK, S_SPILL1, S_SPILL2, S_FINAL, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ROT_R, ROT_G, ROT_B
  } rot_t;

  localparam int CH_W  = pba_pkg::CH_W;
  localparam int FX_W  = pba_pkg::FX_W;

  state_t                              state;
  rot_t                                rot;
  logic [pba_pkg::COUNT_W-1:0]         palette_count;
  logic [pba_pkg::IDX_W-1:0]           idx_q;
  pba_pkg::cmd_t                       cmd_q;
  logic [pba_pkg::TGT_W-1:0]           tgt_q;
  logic [pba_pkg::COLOR_W-1:0]         rdata;
  logic [pba_pkg::COLOR_W-1:0]         palette [pba_pkg::PALETTE_DEPTH];
  logic [2:0][pba_pkg::NUM_W-1:0]      num_q;
  logic [pba_pkg::SUM_W-1:0]           sum_q;
  logic [FX_W-1:0]                     fa;
  logic [FX_W-1:0]                     fb;
  logic [FX_W-1:0]                     fc;
  logic [CH_W-1:0]                     res_r;
  logic [CH_W-1:0]                     res_g;
  logic [CH_W-1:0]                     res_b;
  logic                                res_ok;
  logic                                out_valid;
  logic [CH_W-1:0]                     out_r;
  logic [CH_W-1:0]                     out_g;
  logic [CH_W-1:0]                     out_b;
  logic                                out_ok;

  logic                                accept;
  logic                                idx_ok;
  logic                                cfg_write;
  logic                                mem_we;
  logic [pba_pkg::IDX_W-1:0]           mem_addr;
  logic [pba_pkg::COLOR_W-1:0]         mem_wdata;
  logic [CH_W-1:0]                     t_clamp;
  logic [15:0]                         t_recip;
  logic [CH_W-1:0]                     t_third;
  logic [CH_W-1:0]                     ch_r;
  logic [CH_W-1:0]                     ch_g;
  logic [CH_W-1:0]                     ch_b;
  logic [pba_pkg::SUM_W-1:0]           sum;
  logic [2:0][pba_pkg::NUM_W-1:0]      num;
  logic [FX_W-1:0]                     half;
  logic [FX_W-1:0]                     spill_b;
  logic [FX_W-1:0]                     spill_c;
  logic [CH_W-1:0]                     fin_r;
  logic [CH_W-1:0]                     fin_g;
  logic [CH_W-1:0]                     fin_b;
  logic                                div_start;
  logic                                div_done;
  logic [2:0][pba_pkg::QUO_W-1:0]      div_quo;

  function automatic logic [CH_W-1:0] fx_to_ch(input logic [FX_W-1:0] v);
    if (v[FX_W-1:pba_pkg::FRAC_BITS] > (FX_W - pba_pkg::FRAC_BITS)'(pba_pkg::CH_MAX)) begin
      return pba_pkg::CH_MAX;
    end
    return v[pba_pkg::FRAC_BITS +: CH_W];
  endfunction

  function automatic logic [FX_W-1:0] fx_sat(input logic [FX_W-1:0] v);
    return (v > pba_pkg::LIMIT_FX) ? pba_pkg::LIMIT_FX : v;
  endfunction

  function automatic logic [pba_pkg::NUM_W-1:0] scale3(input logic [CH_W-1:0] c,
                                                       input logic [CH_W-1:0] t);
    logic [2*CH_W-1:0] p;
    p = (2*CH_W)'(c) * (2*CH_W)'(t);
    return pba_pkg::NUM_W'({p, 1'b0}) + pba_pkg::NUM_W'(p);
  endfunction

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == pba_pkg::REG_COUNT_ADDR);
  assign prdata    = (paddr == pba_pkg::REG_COUNT_ADDR) ?
                     pba_pkg::PDATA_W'(palette_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= pba_pkg::COUNT_RESET;
    end else if (cfg_write) begin
      palette_count <= pwdata[pba_pkg::COUNT_W-1:0];
    end
  end

  // Command intake
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && (state == S_IDLE);
  assign idx_ok    = {1'b0, req.entry_index} < palette_count;

  // Adjust setup
  assign ch_r    = rdata[2*CH_W +: CH_W];
  assign ch_g    = rdata[CH_W +: CH_W];
  assign ch_b    = rdata[0 +: CH_W];
  assign t_clamp = tgt_q[pba_pkg::TGT_W-1] ? '0 :
                   (tgt_q[CH_W] ? pba_pkg::CH_MAX : tgt_q[CH_W-1:0]);
  assign t_recip = 16'(t_clamp) * 16'(pba_pkg::RECIP3);
  assign t_third = CH_W'(t_recip >> pba_pkg::RECIP3_SHIFT);
  assign sum     = pba_pkg::SUM_W'(ch_r) + pba_pkg::SUM_W'(ch_g) + pba_pkg::SUM_W'(ch_b);
  assign num[0]  = scale3(ch_r, t_clamp);
  assign num[1]  = scale3(ch_g, t_clamp);
  assign num[2]  = scale3(ch_b, t_clamp);

  assign div_start = (state == S_LAUNCH);

  pba_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_q),
    .den   (sum_q),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Spill arithmetic
  assign half    = ((fa - pba_pkg::LIMIT_FX) >> 1) & pba_pkg::INT_MASK;
  assign spill_b = fc + ((fb - pba_pkg::LIMIT_FX) & pba_pkg::INT_MASK);
  assign spill_c = fb + ((fc - pba_pkg::LIMIT_FX) & pba_pkg::INT_MASK);

  always_comb begin
    case (rot)
      ROT_G: begin
        fin_r = fx_to_ch(fc);
        fin_g = fx_to_ch(fa);
        fin_b = fx_to_ch(fb);
      end
      ROT_B: begin
        fin_r = fx_to_ch(fb);
        fin_g = fx_to_ch(fc);
        fin_b = fx_to_ch(fa);
      end
      default: begin
        fin_r = fx_to_ch(fa);
        fin_g = fx_to_ch(fb);
        fin_b = fx_to_ch(fc);
      end
    endcase
  end

  // Palette storage
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx_q;
    mem_wdata = {fin_r, fin_g, fin_b};
    if (accept && idx_ok && (req.cmd == pba_pkg::CMD_WRITE)) begin
      mem_we    = 1'b1;
      mem_addr  = req.entry_index;
      mem_wdata = {req.new_red, req.new_green, req.new_blue};
    end else if (state == S_FINAL) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      palette[mem_addr] <= mem_wdata;
    end
    if (state == S_IDLE) begin
      rdata <= palette[req.entry_index];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rot       <= ROT_R;
    end else begin
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            idx_q <= req.entry_index;
            tgt_q <= req.target_brightness;
            if (!idx_ok) begin
              res_r  <= '0;
              res_g  <= '0;
              res_b  <= '0;
              res_ok <= 1'b0;
              state  <= S_DONE;
            end else begin
              case (req.cmd)
                pba_pkg::CMD_WRITE: begin
                  res_r  <= req.new_red;
                  res_g  <= req.new_green;
                  res_b  <= req.new_blue;
                  res_ok <= 1'b1;
                  state  <= S_DONE;
                end
                pba_pkg::CMD_ADJUST: begin
                  cmd_q <= pba_pkg::CMD_ADJUST;
                  state <= S_FETCH;
                end
                default: begin
                  cmd_q <= pba_pkg::CMD_READ;
                  state <= S_FETCH;
                end
              endcase
            end
          end
        end
        S_FETCH: begin
          if (cmd_q == pba_pkg::CMD_ADJUST) begin
            if (sum == '0) begin
              fa    <= {FX_W'(t_third)} << pba_pkg::FRAC_BITS;
              fb    <= {FX_W'(t_third)} << pba_pkg::FRAC_BITS;
              fc    <= {FX_W'(t_third)} << pba_pkg::FRAC_BITS;
              rot   <= ROT_R;
              state <= S_FINAL;
            end else begin
              num_q <= num;
              sum_q <= sum;
              state <= S_LAUNCH;
            end
          end else begin
            res_r  <= ch_r;
            res_g  <= ch_g;
            res_b  <= ch_b;
            res_ok <= 1'b1;
            state  <= S_DONE;
          end
        end
        S_LAUNCH: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            fa    <= FX_W'(div_quo[0]);
            fb    <= FX_W'(div_quo[1]);
            fc    <= FX_W'(div_quo[2]);
            rot   <= ROT_R;
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (fa > pba_pkg::LIMIT_FX) begin
            state <= S_SPILL1;
          end else if (fb > pba_pkg::LIMIT_FX) begin
            fa    <= fb;
            fb    <= fc;
            fc    <= fa;
            rot   <= ROT_G;
            state <= S_SPILL1;
          end else if (fc > pba_pkg::LIMIT_FX) begin
            fa    <= fc;
            fb    <= fa;
            fc    <= fb;
            rot   <= ROT_B;
            state <= S_SPILL1;
          end else begin
            state <= S_FINAL;
          end
        end
        S_SPILL1: begin
          fa    <= pba_pkg::LIMIT_FX;
          fb    <= fb + half;
          fc    <= fc + half;
          state <= S_SPILL2;
        end
        S_SPILL2: begin
          if (fb > pba_pkg::LIMIT_FX) begin
            fc <= fx_sat(spill_b);
            fb <= pba_pkg::LIMIT_FX;
          end else if (fc > pba_pkg::LIMIT_FX) begin
            fb <= fx_sat(spill_c);
            fc <= pba_pkg::LIMIT_FX;
          end
          state <= S_FINAL;
        end
        S_FINAL: begin
          res_r  <= fin_r;
          res_g  <= fin_g;
          res_b  <= fin_b;
          res_ok <= 1'b1;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_r     <= res_r;
            out_g     <= res_g;
            out_b     <= res_b;
            out_ok    <= res_ok;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.out_red   = out_r;
  assign rsp.out_green = out_g;
  assign rsp.out_blue  = out_b;
  assign rsp.ok        = out_ok;

endmodule

>>> rtl/core/pba_div.sv
// Three-lane bit-serial restoring divider with a shared divisor.
// Produces one quotient bit per lane per cycle while busy; depends on pba_pkg.
module pba_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [2:0][pba_pkg::NUM_W-1:0]        num,
  input  logic [pba_pkg::SUM_W-1:0]             den,
  output logic                                  done,
  output logic [2:0][pba_pkg::QUO_W-1:0]        quo
);

  localparam int CNT_W = $clog2(pba_pkg::QUO_W);

  logic                                  busy;
  logic [CNT_W-1:0]                      cnt;
  logic [pba_pkg::SUM_W-1:0]             den_q;
  logic [2:0][pba_pkg::REM_W-1:0]        rem;
  logic [2:0][pba_pkg::REM_W-1:0]        rem_next;
  logic [2:0][pba_pkg::QUO_W-1:0]        quo_next;

  always_comb begin
    logic [pba_pkg::REM_W:0] trial;
    logic [pba_pkg::REM_W:0] diff;
    logic                    ge;
    for (int i = 0; i < 3; i++) begin
      trial       = {rem[i], quo[i][pba_pkg::QUO_W-1]};
      diff        = trial - {1'b0, den_q};
      ge          = trial >= {1'b0, den_q};
      rem_next[i] = ge ? diff[pba_pkg::REM_W-1:0] : trial[pba_pkg::REM_W-1:0];
      quo_next[i] = {quo[i][pba_pkg::QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        den_q <= den;
        for (int i = 0; i < 3; i++) begin
          rem[i] <= pba_pkg::REM_W'(num[i][pba_pkg::NUM_W-1 -: pba_pkg::HEAD_W]);
          quo[i] <= {num[i][pba_pkg::NUM_W-pba_pkg::HEAD_W-1:0],
                     pba_pkg::FRAC_BITS'(0)};
        end
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(pba_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for palette_brightness_adjust: write, read and brightness adjust commands,
// directed and random, checked against an in-bench palette model; both sides idle at random.
// Depends on pba_pkg, pba_req_if, pba_rsp_if and the block's RTL.
module tb;

  localparam int CMD_W         = pba_pkg::CMD_W;
  localparam int IDX_W         = pba_pkg::IDX_W;
  localparam int CH_W          = pba_pkg::CH_W;
  localparam int TGT_W         = pba_pkg::TGT_W;
  localparam int COLOR_W       = pba_pkg::COLOR_W;
  localparam int COUNT_W       = pba_pkg::COUNT_W;
  localparam int PADDR_W       = pba_pkg::PADDR_W;
  localparam int PDATA_W       = pba_pkg::PDATA_W;
  localparam int PALETTE_DEPTH = pba_pkg::PALETTE_DEPTH;
  localparam int FRAC_BITS     = pba_pkg::FRAC_BITS;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int MAX_IDLE = 17;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT = 20000;
  localparam longint unsigned CH_LIMIT_FX = 64'(pba_pkg::CH_MAX) << FRAC_BITS;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        idx;
    logic [CH_W-1:0]         red;
    logic [CH_W-1:0]         green;
    logic [CH_W-1:0]         blue;
    logic signed [TGT_W-1:0] tgt;
  } pal_cmd_t;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            ok;
  } entry_result_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  pba_req_if req_ch();
  pba_rsp_if rsp_ch();

  palette_brightness_adjust dut (
    .clk,
    .rst,
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  logic [COLOR_W-1:0] palette_model [PALETTE_DEPTH];
  bit                 written [PALETTE_DEPTH];
  logic [COUNT_W-1:0] entry_count;
  entry_result_t      expected_entries [$];
  bit                 gaps_on;
  bit                 stalls_on;
  int                 hold_off_cycles;
  int                 n_cmds;
  int                 n_adjusts;
  int                 n_rejected;
  int                 n_results;
  int                 n_errors;
  int                 n_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_entries.size());
    $display("Verification failed");
    $finish;
  end

  function automatic longint unsigned whole_part(longint unsigned v);
    return (v >> FRAC_BITS) << FRAC_BITS;
  endfunction

  function automatic logic [COLOR_W-1:0] rescale_color(logic [COLOR_W-1:0] color,
                                                       logic signed [TGT_W-1:0] tgt);
    longint unsigned ch [3];
    longint unsigned t, sum, half;
    logic [CH_W-1:0] third;
    int a, b, c;
    if (tgt < 0) t = 0;
    else if (tgt > 255) t = 255;
    else t = tgt;
    for (int i = 0; i < 3; i++) ch[i] = color[(2 - i) * CH_W +: CH_W];
    sum = ch[0] + ch[1] + ch[2];
    if (sum == 0) begin
      third = CH_W'(t / 3);
      return {third, third, third};
    end
    for (int i = 0; i < 3; i++) ch[i] = ((ch[i] * 3 * t) << FRAC_BITS) / sum;
    a = -1;
    for (int i = 2; i >= 0; i--) if (ch[i] > CH_LIMIT_FX) a = i;
    if (a >= 0) begin
      b = (a + 1) % 3;
      c = (a + 2) % 3;
      half = whole_part((ch[a] - CH_LIMIT_FX) >> 1);
      ch[a] = CH_LIMIT_FX;
      ch[b] += half;
      ch[c] += half;
      if (ch[b] > CH_LIMIT_FX) begin
        ch[c] += whole_part(ch[b] - CH_LIMIT_FX);
        ch[b] = CH_LIMIT_FX;
        if (ch[c] > CH_LIMIT_FX) ch[c] = CH_LIMIT_FX;
      end else if (ch[c] > CH_LIMIT_FX) begin
        ch[b] += whole_part(ch[c] - CH_LIMIT_FX);
        ch[c] = CH_LIMIT_FX;
        if (ch[b] > CH_LIMIT_FX) ch[b] = CH_LIMIT_FX;
      end
    end
    for (int i = 0; i < 3; i++) begin
      ch[i] = ch[i] >> FRAC_BITS;
      if (ch[i] > 255) ch[i] = 255;
    end
    return {CH_W'(ch[0]), CH_W'(ch[1]), CH_W'(ch[2])};
  endfunction

  function automatic entry_result_t palette_after_cmd(pal_cmd_t c);
    entry_result_t res;
    logic [COLOR_W-1:0] color;
    res = '{default: '0};
    if (c.idx >= entry_count || c.idx >= PALETTE_DEPTH) return res;
    if (c.cmd == pba_pkg::CMD_WRITE) begin
      palette_model[c.idx] = {c.red, c.green, c.blue};
      written[c.idx] = 1'b1;
    end else if (c.cmd == pba_pkg::CMD_ADJUST) begin
      palette_model[c.idx] = rescale_color(palette_model[c.idx], c.tgt);
    end
    color = palette_model[c.idx];
    res.red   = color[2 * CH_W +: CH_W];
    res.green = color[CH_W +: CH_W];
    res.blue  = color[0 +: CH_W];
    res.ok    = 1'b1;
    return res;
  endfunction

  function automatic pal_cmd_t make_cmd(logic [CMD_W-1:0] op, int idx, int r, int g, int b,
                                        int tgt);
    pal_cmd_t c;
    c.cmd   = op;
    c.idx   = IDX_W'(idx);
    c.red   = CH_W'(r);
    c.green = CH_W'(g);
    c.blue  = CH_W'(b);
    c.tgt   = TGT_W'(tgt);
    return c;
  endfunction

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CH_W'($urandom_range(0, 3));
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [TGT_W-1:0] rand_target();
    case ($urandom_range(0, 9))
      0, 1: return TGT_W'($urandom_range(256, 511));
      2, 3: return TGT_W'($urandom_range(512, 1023));
      4: return TGT_W'(255);
      default: return TGT_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pal_cmd_t rand_cmd();
    pal_cmd_t c;
    int unsigned sel;
    int unsigned span;
    sel = $urandom_range(0, 99);
    if (sel < 38) c.cmd = pba_pkg::CMD_WRITE;
    else if (sel < 75) c.cmd = pba_pkg::CMD_ADJUST;
    else if (sel < 95) c.cmd = pba_pkg::CMD_READ;
    else c.cmd = CMD_SPARE;
    span = (entry_count > PALETTE_DEPTH) ? PALETTE_DEPTH : entry_count;
    if (span != 0 && $urandom_range(0, 99) < 85) c.idx = IDX_W'($urandom_range(0, span - 1));
    else c.idx = IDX_W'($urandom);
    c.red   = rand_channel();
    c.green = rand_channel();
    c.blue  = rand_channel();
    c.tgt   = rand_target();
    return c;
  endfunction

  function automatic bit field_matches(string name, logic [CH_W-1:0] want,
                                       logic [CH_W-1:0] got);
    if (want === got) return 1'b1;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1'b0;
  endfunction

  task automatic send_cmd(pal_cmd_t c);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
    // never touch an entry that has not been written
    if (c.cmd != pba_pkg::CMD_WRITE && c.idx < entry_count && !written[c.idx])
      c.cmd = pba_pkg::CMD_WRITE;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid             <= 1'b1;
    req_ch.cmd               <= c.cmd;
    req_ch.entry_index       <= c.idx;
    req_ch.new_red           <= c.red;
    req_ch.new_green         <= c.green;
    req_ch.new_blue          <= c.blue;
    req_ch.target_brightness <= c.tgt;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    n_cmds++;
    if (c.cmd == pba_pkg::CMD_ADJUST) n_adjusts++;
    if (c.idx >= entry_count) n_rejected++;
    expected_entries.push_back(palette_after_cmd(c));
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    while (expected_entries.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_entries.size() != 0) begin
      n_errors += expected_entries.size();
      $display("%0t: %0d expected results never arrived", $time, expected_entries.size());
      expected_entries.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(bit wr, logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= pba_pkg::REG_COUNT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_count_readback();
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b0, '0, rd);
    if (rd !== PDATA_W'(entry_count)) begin
      n_errors++;
      $display("%0t: palette_count readback mismatch, expected %0d, actual %0d",
               $time, entry_count, rd);
    end
    @(posedge clk);
  endtask

  task automatic set_palette_count(logic [COUNT_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b1, PDATA_W'(value), rd);
    entry_count = value;
    n_settings++;
    @(posedge clk);
    check_count_readback();
  endtask

  initial begin : result_monitor
    entry_result_t want;
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      n_results++;
      if (expected_entries.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d ok %0b", $time,
                 rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue, rsp_ch.ok);
      end else begin
        want = expected_entries.pop_front();
        if (!(field_matches("out_red", want.red, rsp_ch.out_red) &
              field_matches("out_green", want.green, rsp_ch.out_green) &
              field_matches("out_blue", want.blue, rsp_ch.out_blue) &
              field_matches("ok", CH_W'(want.ok), CH_W'(rsp_ch.ok))))
          n_errors++;
      end
    end
  end

  task automatic test_reset_state();
    check_count_readback();
  endtask

  task automatic test_directed_commands();
    send_cmd(make_cmd(pba_pkg::CMD_WRITE, 0, 255, 255, 255, 0));
    send_cmd(make_cmd(pba_pkg::CMD_ADJUST, 0, 0, 0, 0, 511));
    send_cmd(make_cmd(pba_pkg::CMD_WRITE, 10, 0, 0, 0, 0));
    send_cmd(make_cmd(pba_pkg::CMD_ADJUST, 10, 0, 0, 0, 200));
    send_cmd(make_cmd(pba_pkg::CMD_WRITE, 11, 1, 2, 3, 0));
    send_cmd(make_cmd(pba_pkg::CMD_READ, 11, 0, 0, 0, 0));
    send_cmd(make_cmd(pba_pkg::CMD_WRITE, 1, 200, 100, 0, 0));
    send_cmd(make_cmd(pba_pkg::CMD_ADJUST, 1, 0, 0, 0, 200));
    send_cmd(make_cmd(pba_pkg::CMD_WRITE, 2, 0, 200, 100, 0));
    send_cmd(make_cmd(pba_pkg::CMD_ADJUST, 2, 0, 0, 0, 200));
    send_cmd(make_cmd(pba_pkg::CMD_WRITE, 3, 10, 20, 250, 0));
    send_cmd(make_cmd(pba_pkg::CMD_ADJUST, 3, 0, 0, 0, 255));
    send_cmd(make_cmd(pba_pkg::CMD_WRITE, 4, 1, 2, 3, 0));
    send_cmd(make_cmd(pba_pkg::CMD_ADJUST, 4, 0, 0, 0, -512));
    send_cmd(make_cmd(pba_pkg::CMD_ADJUST, 4, 0, 0, 0, 256));
    send_cmd(make_cmd(CMD_SPARE, 4, 0, 0, 0, 0));
    send_cmd(make_cmd(pba_pkg::CMD_ADJUST, 0, 0, 0, 0, -1));
    drain_results();
  endtask

  task automatic test_count_extremes();
    set_palette_count(COUNT_W'(0));
    send_cmd(make_cmd(pba_pkg::CMD_WRITE, 0, 9, 9, 9, 0));
    send_cmd(make_cmd(pba_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(pba_pkg::CMD_ADJUST, 0, 0, 0, 0, 100));
    drain_results();
    set_palette_count(COUNT_W'(511));
    send_cmd(make_cmd(pba_pkg::CMD_WRITE, 255, 170, 85, 1, 0));
    send_cmd(make_cmd(pba_pkg::CMD_ADJUST, 255, 0, 0, 0, 511));
    send_cmd(make_cmd(pba_pkg::CMD_READ, 255, 0, 0, 0, 0));
    drain_results();
    set_palette_count(COUNT_W'(1));
    send_cmd(make_cmd(pba_pkg::CMD_WRITE, 1, 50, 60, 70, 0));
    send_cmd(make_cmd(pba_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(pba_pkg::CMD_ADJUST, 0, 0, 0, 0, 90));
    drain_results();
  endtask

  task automatic test_random_phases();
    logic [COUNT_W-1:0] counts [7];
    int sizes [7];
    counts = '{COUNT_W'(256), COUNT_W'($urandom_range(2, 255)), COUNT_W'(1), COUNT_W'(511),
               COUNT_W'(0), COUNT_W'($urandom_range(1, 256)), COUNT_W'(256)};
    sizes = '{300, 250, 80, 200, 30, 200, 120};
    foreach (counts[p]) begin
      set_palette_count(counts[p]);
      for (int i = 0; i < sizes[p]; i++) begin
        if (i % 50 == 0) begin
          gaps_on   = $urandom_range(0, 3) != 0;
          stalls_on = $urandom_range(0, 3) != 0;
        end
        send_cmd(rand_cmd());
      end
      drain_results();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_backpressure();
    pal_cmd_t c;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    // hold the result side off while the command side keeps offering items
    hold_off_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      c = rand_cmd();
      if (i % 2 == 0) c.cmd = pba_pkg::CMD_ADJUST;
      send_cmd(c);
    end
    drain_results();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_paused_bursts();
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 20; i++) send_cmd(rand_cmd());
      drain_results();
    end
  endtask

  initial begin
    rst                      <= 1'b1;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    req_ch.valid             <= 1'b0;
    req_ch.cmd               <= pba_pkg::CMD_READ;
    req_ch.entry_index       <= '0;
    req_ch.new_red           <= '0;
    req_ch.new_green         <= '0;
    req_ch.new_blue          <= '0;
    req_ch.target_brightness <= '0;
    entry_count     = pba_pkg::COUNT_RESET;
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    hold_off_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_commands();
    test_count_extremes();
    test_random_phases();
    test_backpressure();
    test_paused_bursts();

    $display("Covered %0d commands (%0d adjusts, %0d rejected) and %0d results", n_cmds,
             n_adjusts, n_rejected, n_results);
    $display("across %0d palette_count writes, with idling, long stalls and pauses",
             n_settings);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d errors", n_errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
